// ===== hw/rtl/uvst_pkg.sv =====
// Package: shared constants, types and trig table for the sphere tessellator.
`timescale 1ns / 1ps
package uvst_pkg;
    localparam int MAX_RINGS_DEF    = 7;
    localparam int MAX_SEGMENTS_DEF = 7;
    localparam int FULL_TURN    = 840;
    localparam int HALF_TURN    = 420;
    localparam int QUARTER_TURN = 210;
    localparam int ANG_W = 10;

    typedef enum logic [0:0] {
        CFG_RING_COUNT    = 1'b0,
        CFG_SEGMENT_COUNT = 1'b1
    } cfg_idx_t;

    // multiply request from sequencer to the shared multiplier
    typedef struct packed {
        logic               start;
        logic signed [32:0] a;
        logic signed [17:0] c;
    } mul_req_t;

    // cosine, angle in units of pi/420, 16 fractional bits
    function automatic logic signed [17:0] cos_units(input logic [ANG_W:0] t_in);
        logic [ANG_W:0] t;
        logic           neg;
        logic [16:0]    v;
        begin
            t   = (t_in >= (ANG_W+1)'(FULL_TURN)) ? t_in - (ANG_W+1)'(FULL_TURN) : t_in;
            neg = 1'b0;
            if (t > (ANG_W+1)'(HALF_TURN)) t = (ANG_W+1)'(FULL_TURN) - t;
            if (t > (ANG_W+1)'(QUARTER_TURN))
            begin
                t   = (ANG_W+1)'(HALF_TURN) - t;
                neg = 1'b1;
            end
            case (t)
                11'd0:   v = 17'd65536;
                11'd60:  v = 17'd59046;
                11'd70:  v = 17'd56756;
                11'd84:  v = 17'd53020;
                11'd105: v = 17'd46341;
                11'd120: v = 17'd40861;
                11'd140: v = 17'd32768;
                11'd168: v = 17'd20252;
                11'd180: v = 17'd14583;
                default: v = 17'd0;
            endcase
            cos_units = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
        end
    endfunction

    function automatic logic signed [17:0] sin_units(input logic [ANG_W:0] t);
        logic [ANG_W:0] u;
        begin
            u = (t >= (ANG_W+1)'(FULL_TURN)) ? t - (ANG_W+1)'(FULL_TURN) : t;
            sin_units = cos_units(u + (ANG_W+1)'(630) -
                ((u + (ANG_W+1)'(630) >= (ANG_W+1)'(FULL_TURN)) ? (ANG_W+1)'(FULL_TURN)
                                                                 : (ANG_W+1)'(0)));
        end
    endfunction
endpackage

// ===== hw/rtl/uvst_mul.sv =====
// Shared Q16.16 multiplier with round-half-away-from-zero, one registered result.
`timescale 1ns / 1ps
module uvst_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  uvst_pkg::mul_req_t  req,
    output logic                done,
    output logic signed [32:0]  prod
);
    import uvst_pkg::*;

    logic        neg;
    logic [32:0] ua;
    logic [17:0] uc;
    logic [50:0] m;
    logic [34:0] mr;
    logic signed [32:0] res_next;
    logic        done_reg;
    logic signed [32:0] prod_reg;

    always_comb
    begin
        neg = req.a[32] ^ req.c[17];
        ua  = req.a[32] ? 33'(-req.a) : 33'(req.a);
        uc  = req.c[17] ? 18'(-req.c) : 18'(req.c);
        m   = 51'(ua) * 51'(uc) + 51'd32768;
        mr  = m[50:16];
        res_next = neg ? -$signed(mr[32:0]) : $signed(mr[32:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) prod_reg <= res_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;
endmodule

// ===== hw/rtl/uv_sphere_tessellator_unit.sv =====
// Top level: sphere tessellator sequencer around one shared multiplier.
`timescale 1ns / 1ps
// One sphere produces (R+1)*(S+1) vertices. Every multiply goes through one
// shared multiplier: each ring computes rc and z, then each vertex computes x
// and y and then takes an output step; the output step waits while the output
// register is full and the output is stalled.
// in_stall is high whenever a sphere is in work or a vertex still waits in
// the output register.
module uv_sphere_tessellator_unit #(
    parameter int MAX_RINGS    = uvst_pkg::MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = uvst_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               new_mesh,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    input  logic signed [31:0] color_r,
    input  logic signed [31:0] color_g,
    input  logic signed [31:0] color_b,
    input  logic signed [31:0] color_a,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] out_r,
    output logic signed [31:0] out_g,
    output logic signed [31:0] out_b,
    output logic signed [31:0] out_a,
    output logic [31:0]        vertex_number,
    output logic               quad_valid,
    output logic               last_vertex
);
    import uvst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RC, ST_Z, ST_X, ST_Y, ST_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] ring_cfg_reg, seg_cfg_reg;
    logic [2:0] rings_reg, segs_reg, i_reg, j_reg;
    logic [ANG_W:0] a_reg, b_reg, da_reg, db_reg;
    logic [31:0] cnt_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg, cr_reg, cg_reg, cb_reg, ca_reg;
    logic [30:0] rad_reg;
    logic signed [32:0] rc_reg;
    logic [31:0] z_reg, x_reg, y_reg;
    logic wait_reg;
    logic [31:0] px_reg, py_reg, pz_reg, vn_reg;
    logic qv_reg, lv_reg, ov_reg;

    mul_req_t req;
    logic mdone;
    logic signed [32:0] prod;

    uvst_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .prod(prod));

    logic [2:0] rings_eff, segs_eff;
    always_comb
    begin
        rings_eff = (ring_cfg_reg == 3'd0) ? 3'd1 : ring_cfg_reg;
        if (rings_eff > 3'(MAX_RINGS)) rings_eff = 3'(MAX_RINGS);
        segs_eff = (seg_cfg_reg < 3'd3) ? 3'd3 : seg_cfg_reg;
        if (segs_eff > 3'(MAX_SEGMENTS)) segs_eff = 3'(MAX_SEGMENTS);
    end

    logic [ANG_W:0] da_lut, db_lut;
    always_comb
    begin
        case (rings_eff)
            3'd1: da_lut = 11'd420; 3'd2: da_lut = 11'd210; 3'd3: da_lut = 11'd140;
            3'd4: da_lut = 11'd105; 3'd5: da_lut = 11'd84;  3'd6: da_lut = 11'd70;
            default: da_lut = 11'd60;
        endcase
        case (segs_eff)
            3'd3: db_lut = 11'd280; 3'd4: db_lut = 11'd210; 3'd5: db_lut = 11'd168;
            3'd6: db_lut = 11'd140; default: db_lut = 11'd120;
        endcase
    end

    always_comb
    begin
        req.start = 1'b0;
        req.a = $signed({2'b00, rad_reg});
        req.c = 18'sd0;
        if (!wait_reg)
        begin
            case (state_reg)
                ST_RC: begin req.start = 1'b1; req.c = sin_units(a_reg); end
                ST_Z:  begin req.start = 1'b1; req.c = cos_units(a_reg); end
                ST_X:  begin req.start = 1'b1; req.a = rc_reg; req.c = cos_units(b_reg); end
                ST_Y:  begin req.start = 1'b1; req.a = rc_reg; req.c = sin_units(b_reg); end
                default: req.start = 1'b0;
            endcase
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ring_cfg_reg <= 3'd6;
            seg_cfg_reg  <= 3'd6;
            cnt_reg      <= 32'd0;
            wait_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall && state_reg != ST_OUT) ov_reg <= 1'b0;
            if (req.start) wait_reg <= 1'b1;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_RING_COUNT) ring_cfg_reg <= cfg_data;
                        else seg_cfg_reg <= cfg_data;
                    end
                    if (in_valid && !ov_reg)
                    begin
                        if (new_mesh) cnt_reg <= 32'd0;
                        rings_reg <= rings_eff; segs_reg <= segs_eff;
                        da_reg <= da_lut; db_reg <= db_lut;
                        i_reg <= 3'd0; a_reg <= '0;
                        cx_reg <= center_x; cy_reg <= center_y; cz_reg <= center_z;
                        cr_reg <= color_r; cg_reg <= color_g;
                        cb_reg <= color_b; ca_reg <= color_a;
                        rad_reg <= radius;
                        state_reg <= ST_RC;
                    end
                end
                ST_RC:
                    if (mdone)
                    begin
                        wait_reg <= 1'b0; rc_reg <= prod; state_reg <= ST_Z;
                    end
                ST_Z:
                    if (mdone)
                    begin
                        wait_reg <= 1'b0; z_reg <= prod[31:0];
                        j_reg <= 3'd0; b_reg <= '0; state_reg <= ST_X;
                    end
                ST_X:
                    if (mdone)
                    begin
                        wait_reg <= 1'b0; x_reg <= prod[31:0]; state_reg <= ST_Y;
                    end
                ST_Y:
                    if (mdone)
                    begin
                        wait_reg <= 1'b0;
                        y_reg <= prod[31:0];
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                    // hold until the output register is free
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= 1'b1;
                        px_reg <= cx_reg + x_reg;
                        py_reg <= cy_reg + y_reg;
                        pz_reg <= cz_reg + z_reg;
                        vn_reg <= cnt_reg;
                        qv_reg <= (i_reg != 3'd0) && (j_reg != 3'd0);
                        lv_reg <= (i_reg == rings_reg) && (j_reg == segs_reg);
                        cnt_reg <= cnt_reg + 32'd1;
                        if (j_reg != segs_reg)
                        begin
                            j_reg <= j_reg + 3'd1; b_reg <= b_reg + db_reg; state_reg <= ST_X;
                        end
                        else if (i_reg != rings_reg)
                        begin
                            i_reg <= i_reg + 3'd1; a_reg <= a_reg + da_reg; state_reg <= ST_RC;
                        end
                        else state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign pos_z = pz_reg;
    assign out_r = cr_reg;
    assign out_g = cg_reg;
    assign out_b = cb_reg;
    assign out_a = ca_reg;
    assign vertex_number = vn_reg;
    assign quad_valid = qv_reg;
    assign last_vertex = lv_reg;
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the sphere tessellator: directed and random spheres, scoreboard check of every vertex.
`timescale 1ns / 1ps

class sphere_scoreboard;
    typedef struct packed {
        logic [31:0] px, py, pz, r, g, b, a, num;
        logic        quad, last;
    } vertex_t;

    vertex_t     pending_vertices[$];
    logic [2:0]  rings_reg = 3'd6;
    logic [2:0]  segs_reg = 3'd6;
    logic [31:0] vertex_count = 32'd0;
    int          errors = 0;

    function longint cos_q16(int t_in);
        int  t;
        bit  neg;
        longint v;
        t = t_in % 840;
        neg = 0;
        if (t > 420) t = 840 - t;
        if (t > 210)
        begin
            t = 420 - t;
            neg = 1;
        end
        case (t)
            0: v = 65536;
            60: v = 59046;
            70: v = 56756;
            84: v = 53020;
            105: v = 46341;
            120: v = 40861;
            140: v = 32768;
            168: v = 20252;
            180: v = 14583;
            default: v = 0;
        endcase
        return neg ? -v : v;
    endfunction

    function longint sin_q16(int t);
        return cos_q16((t % 840) + 630);
    endfunction

    // round to nearest, ties away from zero
    function longint round_mul(longint x, longint c);
        bit neg;
        longint ux, uc, m;
        neg = (x < 0) != (c < 0);
        ux = x < 0 ? -x : x;
        uc = c < 0 ? -c : c;
        m = (ux * uc + 32768) >>> 16;
        return neg ? -m : m;
    endfunction

    function void write_reg(uvst_pkg::cfg_idx_t idx, logic [2:0] val);
        if (idx == uvst_pkg::CFG_RING_COUNT) rings_reg = val;
        else segs_reg = val;
    endfunction

    function void note_sphere(logic nm, logic [31:0] cx, cy, cz, logic [30:0] rad,
                              logic [31:0] cr, cg, cb, ca);
        int nr, ns, ang_a, ang_b;
        longint rc, z, x, y;
        vertex_t v;
        nr = rings_reg;
        ns = segs_reg;
        if (nr < 1) nr = 1;
        if (nr > 7) nr = 7;
        if (ns < 3) ns = 3;
        if (ns > 7) ns = 7;
        if (nm) vertex_count = 0;
        for (int i = 0; i <= nr; i++)
        begin
            ang_a = i * (420 / nr);
            rc = round_mul(longint'(rad), sin_q16(ang_a));
            z = round_mul(longint'(rad), cos_q16(ang_a));
            for (int j = 0; j <= ns; j++)
            begin
                ang_b = j * (840 / ns);
                x = round_mul(rc, cos_q16(ang_b));
                y = round_mul(rc, sin_q16(ang_b));
                v.px = cx + 32'(x);
                v.py = cy + 32'(y);
                v.pz = cz + 32'(z);
                v.r = cr; v.g = cg; v.b = cb; v.a = ca;
                v.num = vertex_count;
                v.quad = (i > 0 && j > 0);
                v.last = (i == nr && j == ns);
                vertex_count++;
                pending_vertices.push_back(v);
            end
        end
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endfunction

    function void check_vertex(vertex_t got);
        vertex_t e;
        if (pending_vertices.size() == 0)
        begin
            report("unexpected vertex", got.num, 32'd0);
            return;
        end
        e = pending_vertices.pop_front();
        if (got.px !== e.px) report("pos_x", got.px, e.px);
        if (got.py !== e.py) report("pos_y", got.py, e.py);
        if (got.pz !== e.pz) report("pos_z", got.pz, e.pz);
        if (got.r !== e.r) report("out_r", got.r, e.r);
        if (got.g !== e.g) report("out_g", got.g, e.g);
        if (got.b !== e.b) report("out_b", got.b, e.b);
        if (got.a !== e.a) report("out_a", got.a, e.a);
        if (got.num !== e.num) report("vertex_number", got.num, e.num);
        if (got.quad !== e.quad) report("quad_valid", got.quad, e.quad);
        if (got.last !== e.last) report("last_vertex", got.last, e.last);
    endfunction
endclass

module tb_top;
    import uvst_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [0:0] cfg_index = 0;
    logic [2:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic new_mesh = 0;
    logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
    logic [30:0] radius = 0;
    logic signed [31:0] color_r = 0, color_g = 0, color_b = 0, color_a = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] pos_x, pos_y, pos_z, out_r, out_g, out_b, out_a;
    logic [31:0] vertex_number;
    logic quad_valid, last_vertex;

    sphere_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    uv_sphere_tessellator_unit uut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // receiver: stall at random, or hold for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && out_valid && !out_stall)
            sb.check_vertex({pos_x, pos_y, pos_z, out_r, out_g, out_b, out_a,
                             vertex_number, quad_valid, last_vertex});
    end

    task automatic write_cfg(cfg_idx_t idx, logic [2:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sphere(logic nm, logic [31:0] cx, cy, cz, logic [30:0] rad,
                               logic [31:0] cr, cg, cb, ca);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid <= 1'b1;
        new_mesh <= nm;
        center_x <= cx; center_y <= cy; center_z <= cz;
        radius <= rad;
        color_r <= cr; color_g <= cg; color_b <= cb; color_a <= ca;
        do @(posedge clk); while (in_stall);
        sb.note_sphere(nm, cx, cy, cz, rad, cr, cg, cb, ca);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random();
        logic [30:0] rad;
        case ($urandom_range(3))
            0: rad = 31'($urandom);
            1: rad = 31'($urandom_range(32'h7fff_ffff, 32'h7fff_0000));
            default: rad = 31'($urandom_range(32'h0040_0000));
        endcase
        send_sphere($urandom_range(9) == 0, $urandom, $urandom, $urandom, rad,
                    $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        while (sb.pending_vertices.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of fields at reset configuration
        send_sphere(1, 32'h8000_0000, 32'h7fff_ffff, 0, 31'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff);
        send_sphere(0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0,
                    32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
        send_sphere(0, 0, 0, 0, 31'h0001_0000, 1, 2, 3, 4);
        drain();
        // out of range counts clamp; extremes of both registers
        write_cfg(CFG_RING_COUNT, 3'd0);
        write_cfg(CFG_SEGMENT_COUNT, 3'd0);
        send_sphere(1, 0, 0, 0, 31'h7fff_ffff, 5, 6, 7, 8);
        send_sphere(0, 32'hffff_0000, 1, 2, 31'h0000_8000, 5, 6, 7, 8);
        drain();
        write_cfg(CFG_RING_COUNT, 3'd7);
        write_cfg(CFG_SEGMENT_COUNT, 3'd7);
        send_sphere(0, 0, 0, 0, 31'h7fff_ffff, 9, 9, 9, 9);
        drain();
        write_cfg(CFG_SEGMENT_COUNT, 3'd2);
        write_cfg(CFG_RING_COUNT, 3'd1);
        send_sphere(0, 1, 1, 1, 31'h0000_0001, 0, 0, 0, 0);
        drain();

        // long receiver hold so the block backs up onto its input
        write_cfg(CFG_RING_COUNT, 3'd2);
        write_cfg(CFG_SEGMENT_COUNT, 3'd3);
        hold_cycles = 600;
        repeat (4) send_random();
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 53 : 0;
            recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 26 : 0;
            for (int k = 0; k < 4; k++)
            begin
                write_cfg(CFG_RING_COUNT, 3'($urandom_range(7)));
                write_cfg(CFG_SEGMENT_COUNT, 3'($urandom_range(7)));
                repeat (30) send_random();
                drain();
            end
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/uvst_pkg.sv
hw/rtl/uvst_mul.sv
hw/rtl/uv_sphere_tessellator_unit.sv
tb/tb_top.sv
